// ----- hw/rtl/lrupr_pkg.sv -----
package lrupr_pkg;

   // Default geometry of the frame table.
   localparam int MAX_FRAMES_DEF = 8;
   localparam int PAGE_BITS_DEF  = 16;

   // Fixed field widths.
   localparam int FAULT_W   = 16;
   localparam int CFG_W     = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // Register map: the word index is bit 2 of the byte address.
   localparam logic CSR_FRAMES_IDX = 1'b0;
   localparam logic [CFG_W-1:0] FRAMES_RESET = 4'd8;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;
      logic scan;
      logic commit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_done;
      logic out_free;
   } status_type;

endpackage

// ----- hw/rtl/lrupr_ram.sv -----
module lrupr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8,
   localparam int ADDR_W = $clog2(DEPTH > 1 ? DEPTH : 2)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/lrupr_ctrl.sv -----
module lrupr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  lrupr_pkg::status_type status,
   output lrupr_pkg::cmd_type    cmd
);

   lrupr_pkg::state_type state_ff;
   lrupr_pkg::state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lrupr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      cmd.start  = 1'b0;
      cmd.scan   = 1'b0;
      cmd.commit = 1'b0;
      req_stall  = 1'b1;
      case (state_ff)
         lrupr_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = lrupr_pkg::ST_SCAN;
            end
         end
         lrupr_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = lrupr_pkg::ST_UPDATE;
            end
         end
         lrupr_pkg::ST_UPDATE: begin
            // Hold the outcome until the result register can take it.
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = lrupr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lrupr_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ----- hw/rtl/lrupr_dp.sv -----
module lrupr_dp #(
   parameter int MAX_FRAMES = lrupr_pkg::MAX_FRAMES_DEF,
   parameter int PAGE_BITS  = lrupr_pkg::PAGE_BITS_DEF,
   localparam int FRAME_W = $clog2(MAX_FRAMES > 1 ? MAX_FRAMES : 2),
   localparam int CNT_W   = $clog2(MAX_FRAMES + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lrupr_pkg::cmd_type            cmd,
   output lrupr_pkg::status_type         status,
   input  logic [lrupr_pkg::CFG_W-1:0]   frames_in_use,
   input  logic [PAGE_BITS-1:0]          req_page_number,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_hit,
   output logic [FRAME_W-1:0]            rsp_frame_index,
   output logic                          rsp_evicted_valid,
   output logic [PAGE_BITS-1:0]          rsp_evicted_page,
   output logic [lrupr_pkg::FAULT_W-1:0] rsp_fault_total
);

   localparam logic [FRAME_W-1:0] RANK_TOP = FRAME_W'(MAX_FRAMES - 1);

   // Working registers of the current reference.
   logic [PAGE_BITS-1:0] page_ff;
   logic [CNT_W-1:0]     scan_idx_ff, scan_idx_in;
   logic                 cmp_live_ff, cmp_live_in;
   logic [FRAME_W-1:0]   cmp_idx_ff;
   logic                 found_ff, found_in;
   logic [FRAME_W-1:0]   hit_idx_ff, hit_idx_in;
   logic                 empty_ff, empty_in;
   logic [FRAME_W-1:0]   empty_idx_ff, empty_idx_in;
   logic [FRAME_W-1:0]   vic_idx_ff, vic_idx_in;
   logic [FRAME_W-1:0]   vic_rank_ff, vic_rank_in;
   logic [PAGE_BITS-1:0] vic_page_ff, vic_page_in;

   // Frame state and counters.
   logic [MAX_FRAMES-1:0] valid_ff, valid_in;
   logic [FRAME_W-1:0]    rank_ff [MAX_FRAMES];
   logic [FRAME_W-1:0]    rank_in [MAX_FRAMES];
   logic [lrupr_pkg::FAULT_W-1:0] fault_ff, fault_in;

   // Result register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_hit_ff;
   logic [FRAME_W-1:0]            rsp_frame_ff;
   logic                          rsp_ev_valid_ff;
   logic [PAGE_BITS-1:0]          rsp_ev_page_ff;
   logic [lrupr_pkg::FAULT_W-1:0] rsp_fault_ff;

   logic [CNT_W-1:0]     n_act;
   logic                 issuing;
   logic [PAGE_BITS-1:0] rd_page;
   logic                 cur_valid;
   logic [FRAME_W-1:0]   cur_rank;
   logic [FRAME_W-1:0]   sel_idx;
   logic [FRAME_W-1:0]   old_rank;
   logic                 do_evict;

   // Number of frames that take part: zero acts as one, large values clamp.
   always_comb begin
      if (frames_in_use == '0) begin
         n_act = CNT_W'(1);
      end else if (int'(frames_in_use) > MAX_FRAMES) begin
         n_act = CNT_W'(MAX_FRAMES);
      end else begin
         n_act = CNT_W'(frames_in_use);
      end
   end

   assign issuing = (scan_idx_ff < n_act);

   // Page store, read one frame per cycle during the scan.
   lrupr_ram #(
      .WIDTH (PAGE_BITS),
      .DEPTH (MAX_FRAMES)
   ) u_page_ram (
      .clock   (clock),
      .wr_en   (cmd.commit & ~found_ff),
      .wr_addr (sel_idx),
      .wr_data (page_ff),
      .rd_addr (scan_idx_ff[FRAME_W-1:0]),
      .rd_data (rd_page)
   );

   assign cur_valid = valid_ff[cmp_idx_ff];
   assign cur_rank  = rank_ff[cmp_idx_ff];

   // Scan: address stage issues a read, compare stage sees the page in the next cycle.
   always_comb begin
      scan_idx_in  = scan_idx_ff;
      cmp_live_in  = 1'b0;
      found_in     = found_ff;
      hit_idx_in   = hit_idx_ff;
      empty_in     = empty_ff;
      empty_idx_in = empty_idx_ff;
      vic_idx_in   = vic_idx_ff;
      vic_rank_in  = vic_rank_ff;
      vic_page_in  = vic_page_ff;
      if (cmd.start) begin
         scan_idx_in = '0;
         found_in    = 1'b0;
         empty_in    = 1'b0;
      end else if (cmd.scan) begin
         if (issuing) begin
            scan_idx_in = scan_idx_ff + CNT_W'(1);
            cmp_live_in = 1'b1;
         end
         if (cmp_live_ff) begin
            // The first matching valid frame is the hit.
            if (cur_valid && rd_page == page_ff && !found_ff) begin
               found_in   = 1'b1;
               hit_idx_in = cmp_idx_ff;
            end
            // The lowest empty frame is the fill target.
            if (!cur_valid && !empty_ff) begin
               empty_in     = 1'b1;
               empty_idx_in = cmp_idx_ff;
            end
            // The oldest frame is the victim; the lowest index wins a tie.
            if (cmp_idx_ff == '0 || cur_rank > vic_rank_ff) begin
               vic_idx_in  = cmp_idx_ff;
               vic_rank_in = cur_rank;
               vic_page_in = rd_page;
            end
         end
      end
   end

   // Frame used by this reference and the rank it leaves behind.
   always_comb begin
      if (found_ff) begin
         sel_idx = hit_idx_ff;
      end else if (empty_ff) begin
         sel_idx = empty_idx_ff;
      end else begin
         sel_idx = vic_idx_ff;
      end
      old_rank = rank_ff[sel_idx];
      do_evict = ~found_ff & ~empty_ff;
   end

   // Commit: recency update, valid bit, fault count.
   always_comb begin
      valid_in = valid_ff;
      fault_in = fault_ff;
      for (int j = 0; j < MAX_FRAMES; j++) begin
         rank_in[j] = rank_ff[j];
      end
      if (cmd.commit) begin
         for (int j = 0; j < MAX_FRAMES; j++) begin
            if (FRAME_W'(j) == sel_idx) begin
               rank_in[j] = '0;
            end else if (CNT_W'(j) < n_act && valid_ff[j] &&
                         (!found_ff || rank_ff[j] < old_rank) &&
                         rank_ff[j] != RANK_TOP) begin
               rank_in[j] = rank_ff[j] + FRAME_W'(1);
            end
         end
         if (!found_ff) begin
            valid_in[sel_idx] = 1'b1;
            if (fault_ff != '1) begin
               fault_in = fault_ff + lrupr_pkg::FAULT_W'(1);
            end
         end
      end
   end

   // The result register frees when the receiver takes the transfer.
   assign rsp_valid_in = cmd.commit | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff  <= '0;
         cmp_live_ff  <= 1'b0;
         found_ff     <= 1'b0;
         empty_ff     <= 1'b0;
         valid_ff     <= '0;
         fault_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j < MAX_FRAMES; j++) begin
            rank_ff[j] <= '0;
         end
      end else begin
         scan_idx_ff  <= scan_idx_in;
         cmp_live_ff  <= cmp_live_in;
         found_ff     <= found_in;
         empty_ff     <= empty_in;
         valid_ff     <= valid_in;
         fault_ff     <= fault_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int j = 0; j < MAX_FRAMES; j++) begin
            rank_ff[j] <= rank_in[j];
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmp_idx_ff   <= scan_idx_ff[FRAME_W-1:0];
      hit_idx_ff   <= hit_idx_in;
      empty_idx_ff <= empty_idx_in;
      vic_idx_ff   <= vic_idx_in;
      vic_rank_ff  <= vic_rank_in;
      vic_page_ff  <= vic_page_in;
      if (cmd.start) begin
         page_ff <= req_page_number;
      end
      if (cmd.commit) begin
         rsp_hit_ff      <= found_ff;
         rsp_frame_ff    <= sel_idx;
         rsp_ev_valid_ff <= do_evict;
         rsp_ev_page_ff  <= do_evict ? vic_page_ff : '0;
         rsp_fault_ff    <= fault_in;
      end
   end

   assign status.scan_done = ~issuing;
   assign status.out_free  = ~rsp_valid_ff | ~rsp_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_frame_index   = rsp_frame_ff;
   assign rsp_evicted_valid = rsp_ev_valid_ff;
   assign rsp_evicted_page  = rsp_ev_page_ff;
   assign rsp_fault_total   = rsp_fault_ff;

endmodule

// ----- hw/rtl/lru_page_replacement.sv -----
// LRU page replacement over a small set of physical frames.
// Input channel (req_valid / req_stall / req_page_number): one page reference
// per transfer. Result channel (rsp_valid / rsp_stall / rsp_*): one result per
// reference with hit, frame used, evicted page and the saturating fault count.
// The CSR port holds frames_in_use (byte address 0); write it only while idle.
// Each reference passes an accept step, the frame scan over the frames in use,
// which reads the page store one frame per cycle with a registered read, and
// an update step that writes the frame state and the result register. The
// result is offered as the block returns to idle, so the next reference can be
// accepted while that result is still on offer.
// While the receiver stalls, the result stays in its register and the next
// reference may still be accepted and scanned; its update waits until the
// pending result has been taken.
// Reset clears all valid bits, recency ranks and the fault count, and sets
// frames_in_use to eight. Page contents are not cleared; no clearing pass runs.
module lru_page_replacement #(
   parameter int MAX_FRAMES = lrupr_pkg::MAX_FRAMES_DEF,
   parameter int PAGE_BITS  = lrupr_pkg::PAGE_BITS_DEF,
   localparam int FRAME_W = $clog2(MAX_FRAMES > 1 ? MAX_FRAMES : 2)
) (
   input  logic                             clock,
   input  logic                             reset,
   // Input channel.
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [PAGE_BITS-1:0]             req_page_number,
   // Result channel.
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_hit,
   output logic [FRAME_W-1:0]               rsp_frame_index,
   output logic                             rsp_evicted_valid,
   output logic [PAGE_BITS-1:0]             rsp_evicted_page,
   output logic [lrupr_pkg::FAULT_W-1:0]    rsp_fault_total,
   // Configuration port.
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [lrupr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [lrupr_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [lrupr_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                             csr_pready
);

   logic [lrupr_pkg::CFG_W-1:0] frames_in_use_ff;
   logic [lrupr_pkg::CFG_W-1:0] frames_in_use_in;
   logic                        csr_wr;
   lrupr_pkg::cmd_type          cmd;
   lrupr_pkg::status_type       status;

   // Configuration register write on the access phase.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      frames_in_use_in = frames_in_use_ff;
      if (csr_wr && csr_paddr[2] == lrupr_pkg::CSR_FRAMES_IDX) begin
         frames_in_use_in = csr_pwdata[lrupr_pkg::CFG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_in_use_ff <= lrupr_pkg::FRAMES_RESET;
      end else begin
         frames_in_use_ff <= frames_in_use_in;
      end
   end

   // Register readback.
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == lrupr_pkg::CSR_FRAMES_IDX) begin
         csr_prdata = lrupr_pkg::CSR_DATA_W'(frames_in_use_ff);
      end
   end

   lrupr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lrupr_dp #(
      .MAX_FRAMES (MAX_FRAMES),
      .PAGE_BITS  (PAGE_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .frames_in_use     (frames_in_use_ff),
      .req_page_number   (req_page_number),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hit           (rsp_hit),
      .rsp_frame_index   (rsp_frame_index),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_fault_total   (rsp_fault_total)
   );

   // After an input transfer the block is busy with that reference.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input accepted twice in a row");

   // An update never overwrites a result that is still waiting.
   a_commit_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid || !rsp_stall))
      else $error("result register overwritten while stalled");

   // A hit never evicts.
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_hit && rsp_evicted_valid))
      else $error("hit reported with an eviction");

   // Without an eviction the evicted page reads as zero.
   a_evict_page_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_evicted_valid) |-> (rsp_evicted_page == '0))
      else $error("evicted page nonzero without an eviction");

endmodule

// ----- tb/lru_checker.sv -----
`timescale 1ns / 100ps

// Watches the reference, result and CSR ports of the LRU page replacement block,
// keeps its own copy of the frame table and compares every result transfer
// against the oldest outstanding prediction.
module lru_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic [15:0]                      req_page_number,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic                             rsp_hit,
   input  logic [2:0]                       rsp_frame_index,
   input  logic                             rsp_evicted_valid,
   input  logic [15:0]                      rsp_evicted_page,
   input  logic [lrupr_pkg::FAULT_W-1:0]    rsp_fault_total,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic                             csr_pready,
   input  logic [lrupr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [lrupr_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output int                               mismatches,
   output int                               in_flight
);

   localparam int FRAMES = 8;
   localparam int OLDEST = FRAMES - 1;

   typedef struct packed {
      logic        hit;
      logic [2:0]  frame;
      logic        evicted_valid;
      logic [15:0] evicted_page;
      logic [15:0] faults;
   } access_result_type;

   // Shadow copy of the frame table and the frame count register.
   logic [15:0]                 shadow_page  [FRAMES];
   logic                        shadow_valid [FRAMES];
   logic [2:0]                  shadow_age   [FRAMES];
   logic [15:0]                 shadow_faults;
   logic [lrupr_pkg::CFG_W-1:0] frames_setting;

   access_result_type expected_accesses[$];
   int                error_count;

   // Make frame f the newest; frames younger than its previous age move back one.
   function automatic void refresh_age(input int n, input int f, input int prior_age);
      for (int j = 0; j < n; j++) begin
         if (j != f && shadow_valid[j] && int'(shadow_age[j]) < prior_age &&
             int'(shadow_age[j]) < OLDEST) begin
            shadow_age[j] = shadow_age[j] + 3'd1;
         end
      end
      shadow_age[f] = 3'd0;
   endfunction

   // Look up one page reference, update the shadow table and return the result.
   function automatic access_result_type lookup_page(input logic [15:0] page);
      int                n;
      int                f;
      int                best;
      bit                found;
      bit                empty;
      access_result_type r;
      n     = (frames_setting == 0) ? 1 : (frames_setting > FRAMES) ? FRAMES :
              int'(frames_setting);
      f     = 0;
      found = 1'b0;
      empty = 1'b0;
      r     = '0;
      for (int j = 0; j < n; j++) begin
         if (!found && shadow_valid[j] && shadow_page[j] == page) begin
            f     = j;
            found = 1'b1;
         end
      end
      if (found) begin
         r.hit = 1'b1;
         refresh_age(n, f, int'(shadow_age[f]));
      end else begin
         if (shadow_faults != 16'hFFFF) begin
            shadow_faults = shadow_faults + 16'd1;
         end
         for (int j = 0; j < n; j++) begin
            if (!empty && !shadow_valid[j]) begin
               f     = j;
               empty = 1'b1;
            end
         end
         // No free frame: the oldest one goes, the lowest index winning a tie.
         if (!empty) begin
            best = 0;
            f    = 0;
            for (int j = 0; j < n; j++) begin
               if (j == 0 || int'(shadow_age[j]) > best) begin
                  best = int'(shadow_age[j]);
                  f    = j;
               end
            end
            r.evicted_valid = 1'b1;
            r.evicted_page  = shadow_page[f];
         end
         shadow_page[f]  = page;
         shadow_valid[f] = 1'b1;
         refresh_age(n, f, FRAMES);
      end
      r.frame  = f[2:0];
      r.faults = shadow_faults;
      return r;
   endfunction

   // Track CSR writes, predict on each reference transfer, check each result.
   always @(posedge clock) begin
      access_result_type want;
      access_result_type got;
      if (reset) begin
         for (int j = 0; j < FRAMES; j++) begin
            shadow_page[j]  = '0;
            shadow_valid[j] = 1'b0;
            shadow_age[j]   = '0;
         end
         shadow_faults  = '0;
         frames_setting = lrupr_pkg::FRAMES_RESET;
         error_count    = 0;
         expected_accesses.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[2] == lrupr_pkg::CSR_FRAMES_IDX) begin
            frames_setting = csr_pwdata[lrupr_pkg::CFG_W-1:0];
         end
         if (req_valid && !req_stall) begin
            expected_accesses = {expected_accesses, lookup_page(req_page_number)};
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_hit, rsp_frame_index, rsp_evicted_valid, rsp_evicted_page,
                    rsp_fault_total};
            if (expected_accesses.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result transfer: expected none,",
                        $time,
                        " got hit=%0b frame=%0d ev=%0b/%h faults=%0d",
                        got.hit, got.frame, got.evicted_valid,
                        got.evicted_page, got.faults);
            end else begin
               want = expected_accesses.pop_front();
               if (got !== want) begin
                  error_count++;
                  $display("%0t: result mismatch: expected hit=%0b frame=%0d",
                           $time, want.hit, want.frame,
                           " ev=%0b/%h faults=%0d,", want.evicted_valid,
                           want.evicted_page, want.faults,
                           " got hit=%0b frame=%0d ev=%0b/%h faults=%0d",
                           got.hit, got.frame, got.evicted_valid,
                           got.evicted_page, got.faults);
               end
            end
         end
      end
      mismatches <= error_count;
      in_flight  <= expected_accesses.size();
   end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

// Drives page references and frame count changes into the LRU page replacement
// block, stalls its result channel at random and reports the final verdict.
module testbench;

   localparam int CYCLE_LIMIT    = 3_000_000;
   localparam int REFS_PER_PHASE = 52;
   localparam logic [lrupr_pkg::CSR_ADDR_W-1:0] FRAMES_ADDR =
      {lrupr_pkg::CSR_FRAMES_IDX, 2'b00};
   localparam logic [lrupr_pkg::CFG_W-1:0] PHASE_FRAMES [9] =
      '{4'd3, 4'd1, 4'd0, 4'd15, 4'd5, 4'd8, 4'd7, 4'd2, 4'd11};

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [15:0]                      req_page_number = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic                             rsp_hit;
   logic [2:0]                       rsp_frame_index;
   logic                             rsp_evicted_valid;
   logic [15:0]                      rsp_evicted_page;
   logic [lrupr_pkg::FAULT_W-1:0]    rsp_fault_total;
   logic                             csr_psel = 1'b0;
   logic                             csr_penable = 1'b0;
   logic                             csr_pwrite = 1'b0;
   logic [lrupr_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [lrupr_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [lrupr_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                             csr_pready;

   int          mismatches;
   int          in_flight;
   int unsigned cycle_count = 0;
   bit          quiet_tx = 1'b0;
   bit          quiet_rx = 1'b0;
   int          stall_left = 0;
   bit          stall_now = 1'b0;

   lru_page_replacement dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_page_number   (req_page_number),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hit           (rsp_hit),
      .rsp_frame_index   (rsp_frame_index),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_fault_total   (rsp_fault_total),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   lru_checker lru_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_page_number   (req_page_number),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hit           (rsp_hit),
      .rsp_frame_index   (rsp_frame_index),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_fault_total   (rsp_fault_total),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_pready        (csr_pready),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .mismatches        (mismatches),
      .in_flight         (in_flight)
   );

   always #6 clock = ~clock;

   // Reset is held only at the start of the run, then released.
   initial begin
      repeat (2) @(negedge clock);
      reset <= 1'b0;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Pause length: mostly short, sometimes medium, rarely long.
   function automatic int pause_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 80) begin
         return $urandom_range(1, 3);
      end
      if (roll < 95) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   // The result channel alternates between runs of stall and runs of flow.
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_now  = ($urandom_range(0, 3) == 0);
         stall_left = stall_now ? pause_len() : $urandom_range(1, 8);
      end
      stall_left--;
      rsp_stall <= stall_now && !quiet_rx;
   end

   // One reference transfer, preceded by gap idle cycles.
   task automatic send_ref(input logic [15:0] page, input int gap);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_page_number <= page;
      do @(posedge clock); while (req_stall);
   endtask

   // Stop sending and wait until every predicted result has been taken.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (in_flight != 0) @(negedge clock);
   endtask

   // CSR write of the frame count, with random bits above the register.
   task automatic write_frames(input logic [lrupr_pkg::CFG_W-1:0] count);
      wait_idle();
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= FRAMES_ADDR;
      csr_pwdata  <= {(lrupr_pkg::CSR_DATA_W - lrupr_pkg::CFG_W)'($urandom()), count};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Random references under one frame count, mostly drawn from a small working set.
   task automatic run_phase(input logic [lrupr_pkg::CFG_W-1:0] count, input int refs);
      logic [15:0] working_set[$];
      int          active;
      int          gap;
      logic [15:0] page;
      write_frames(count);
      active = (count == 0) ? 1 : (count > 8) ? 8 : int'(count);
      repeat (active + $urandom_range(1, 3)) begin
         working_set = {working_set, 16'($urandom_range(0, 65535))};
      end
      if ($urandom_range(0, 1) == 1) begin
         working_set[0] = 16'h0000;
         working_set[working_set.size() - 1] = 16'hFFFF;
      end
      for (int i = 0; i < refs; i++) begin
         if ($urandom_range(0, 99) < 85) begin
            page = working_set[$urandom_range(0, working_set.size() - 1)];
         end else begin
            page = 16'($urandom_range(0, 65535));
         end
         gap = (quiet_tx || $urandom_range(0, 1) == 0) ? 0 : pause_len();
         send_ref(page, gap);
         // Now and then let the block drain completely before going on.
         if ($urandom_range(0, 49) == 0) begin
            wait_idle();
         end
      end
   endtask

   initial begin
      wait (!reset);

      // Directed: extreme pages, hits and fills under the reset frame count.
      send_ref(16'h0000, 0);
      send_ref(16'hFFFF, 0);
      send_ref(16'h0000, 2);
      send_ref(16'hFFFF, 0);
      send_ref(16'h5A5A, 0);
      send_ref(16'hA5A5, 1);
      // Two frames: hit, then evictions including page zero.
      write_frames(4'd2);
      send_ref(16'h0000, 0);
      send_ref(16'h1234, 0);
      send_ref(16'hFFFF, 0);
      // A count of zero acts as one frame.
      write_frames(4'd0);
      send_ref(16'h0000, 0);
      send_ref(16'h0000, 0);
      send_ref(16'h8001, 0);
      // Counts above the maximum act as eight; idle frames come back with equal ages.
      write_frames(4'd15);
      send_ref(16'h5A5A, 0);
      send_ref(16'hA5A5, 0);
      send_ref(16'h1111, 0);
      send_ref(16'h2222, 0);
      send_ref(16'h3333, 3);
      send_ref(16'h4444, 0);
      send_ref(16'h7777, 0);
      send_ref(16'h6666, 0);
      write_frames(4'd4);
      send_ref(16'h7777, 0);
      write_frames(4'd8);
      send_ref(16'h7777, 0);

      // Random phases over several frame counts; every third one runs without idling.
      for (int ph = 0; ph < 10; ph++) begin
         quiet_tx = (ph % 3 == 2);
         quiet_rx = (ph % 3 == 2);
         run_phase((ph < 9) ? PHASE_FRAMES[ph] : 4'($urandom_range(0, 15)), REFS_PER_PHASE);
      end

      wait_idle();
      repeat (24) @(posedge clock);
      if (mismatches == 0 && in_flight == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
